// ===== src/csvtok_pkg.sv =====
// csvtok_pkg: types, character codes and helper functions for the csv field tokenizer
// no dependencies; imported by csvtok_step and csv_field_tokenizer_core
`default_nettype none

package csvtok_pkg;

   // widths
   localparam int CHAR_W  = 7;
   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 2;
   localparam int STATE_W = 3;
   localparam int CNT_W   = 2;
   localparam int LEN_W   = 3;

   // parser state codes
   localparam logic [STATE_W-1:0] ST_START = 3'd0;
   localparam logic [STATE_W-1:0] ST_NUM   = 3'd1;
   localparam logic [STATE_W-1:0] ST_QSTR  = 3'd2;
   localparam logic [STATE_W-1:0] ST_QWAIT = 3'd3;
   localparam logic [STATE_W-1:0] ST_WORD  = 3'd4;
   localparam logic [STATE_W-1:0] ST_WWAIT = 3'd5;

   // field kind codes
   localparam logic [KIND_W-1:0] KIND_NUMBER = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUOTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_WORD   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd3;

   // fixed characters
   localparam logic [BYTE_W-1:0] LF_CHAR    = 8'h0A;
   localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
   localparam logic [BYTE_W-1:0] POINT_CHAR = 8'h2E;
   localparam logic [BYTE_W-1:0] DIGIT_LO   = 8'h30;
   localparam logic [BYTE_W-1:0] DIGIT_HI   = 8'h39;

   // register reset values
   localparam logic [CHAR_W-1:0] DELIM_RESET = 7'd44;
   localparam logic [CHAR_W-1:0] QUOTE_RESET = 7'd34;

   // register indexes
   localparam logic REG_DELIM = 1'b0;
   localparam logic REG_QUOTE = 1'b1;

   typedef struct packed {
      logic [STATE_W-1:0] parse_state;
      logic               point_seen;
      logic [CNT_W-1:0]   skip_count;
      logic [CNT_W-1:0]   copy_count;
   } csvtok_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_data;
      logic              out_valid;
      logic              field_end;
      logic [KIND_W-1:0] field_kind;
      logic              number_error;
      logic              line_done;
   } csvtok_result_type;

   // utf-8 sequence length from a lead byte, zero for a continuation byte
   function automatic logic [LEN_W-1:0] u8_len(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] len;
      if ((b & 8'hE0) == 8'hC0)      len = 3'd2;
      else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
      else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
      else if ((b & 8'hC0) == 8'h80) len = 3'd0;
      else                           len = 3'd1;
      return len;
   endfunction

   function automatic logic is_digit(input logic [BYTE_W-1:0] b);
      return (b >= DIGIT_LO) && (b <= DIGIT_HI);
   endfunction

   function automatic logic [KIND_W-1:0] kind_of(input logic [STATE_W-1:0] s);
      logic [KIND_W-1:0] k;
      if (s == ST_QSTR || s == ST_QWAIT)      k = KIND_QUOTED;
      else if (s == ST_WORD || s == ST_WWAIT) k = KIND_WORD;
      else                                    k = KIND_NUMBER;
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== src/csvtok_step.sv =====
// csvtok_step: next parser state and result word for one input byte
// depends on csvtok_pkg
`default_nettype none

module csvtok_step (
   input  csvtok_pkg::csvtok_state_type  cur_state,
   input  logic [7:0]                    in_data,
   input  logic                          line_end,
   input  logic [6:0]                    delimiter_char,
   input  logic [6:0]                    quote_char,
   output csvtok_pkg::csvtok_state_type  nxt_state,
   output csvtok_pkg::csvtok_result_type result
);
   import csvtok_pkg::*;

   logic [BYTE_W-1:0]  delim_byte;
   logic [BYTE_W-1:0]  quote_byte;
   logic [LEN_W-1:0]   len;
   logic [LEN_W-1:0]   len_m1;
   logic               fend;
   logic               skipped;
   logic               run;
   logic [STATE_W-1:0] proc;
   logic [CNT_W-1:0]   next_skip;

   assign delim_byte = {1'b0, delimiter_char};
   assign quote_byte = {1'b0, quote_char};
   assign len        = u8_len(in_data);
   assign len_m1     = len - 3'd1;

   always_comb begin
      nxt_state           = cur_state;
      result              = '0;
      result.line_done    = line_end;
      fend                = 1'b0;
      skipped             = 1'b0;
      run                 = 1'b0;
      proc                = cur_state.parse_state;
      next_skip           = '0;

      if (cur_state.skip_count != '0) begin
         // dropping the rest of a skipped character
         nxt_state.skip_count = cur_state.skip_count - 2'd1;
         skipped = 1'b1;
      end else if (cur_state.copy_count != '0) begin
         // copying continuation bytes of a character
         nxt_state.copy_count = cur_state.copy_count - 2'd1;
         result.out_data   = in_data;
         result.out_valid  = 1'b1;
         result.field_kind = kind_of(cur_state.parse_state);
      end else begin
         // field start picks the kind; a word start is handled as a word byte
         if (cur_state.parse_state == ST_START) begin
            priority if (in_data == LF_CHAR) begin
               fend = 1'b1;
               result.field_kind = KIND_EMPTY;
            end else if (in_data == quote_byte) begin
               nxt_state.parse_state = ST_QSTR;
               result.field_kind = KIND_QUOTED;
            end else if (is_digit(in_data)) begin
               nxt_state.parse_state = ST_NUM;
               result.out_data   = in_data;
               result.out_valid  = 1'b1;
               result.field_kind = KIND_NUMBER;
            end else begin
               nxt_state.parse_state = ST_WORD;
               run  = 1'b1;
               proc = ST_WORD;
            end
         end else begin
            run = 1'b1;
         end

         if (run) begin
            result.field_kind = kind_of(proc);
            unique case (proc)
               ST_WORD: begin
                  priority if (len == '0 || in_data == delim_byte || in_data == SPACE_CHAR) begin
                     fend = 1'b1;
                  end else if (in_data == quote_byte) begin
                     nxt_state.parse_state = ST_WWAIT;
                  end else begin
                     result.out_data      = in_data;
                     result.out_valid     = 1'b1;
                     nxt_state.copy_count = len_m1[CNT_W-1:0];
                  end
               end
               ST_QSTR: begin
                  priority if (len == '0) begin
                     fend = 1'b1;
                  end else if (in_data == quote_byte) begin
                     nxt_state.parse_state = ST_QWAIT;
                  end else begin
                     result.out_data      = in_data;
                     result.out_valid     = 1'b1;
                     nxt_state.copy_count = len_m1[CNT_W-1:0];
                  end
               end
               ST_QWAIT, ST_WWAIT: begin
                  priority if (len == '0) begin
                     fend = 1'b1;
                  end else if (in_data == quote_byte) begin
                     result.out_data  = in_data;
                     result.out_valid = 1'b1;
                     nxt_state.parse_state = (proc == ST_QWAIT) ? ST_QSTR : ST_WORD;
                  end else begin
                     fend      = 1'b1;
                     next_skip = len_m1[CNT_W-1:0];
                  end
               end
               ST_NUM: begin
                  priority if (in_data == delim_byte) begin
                     fend = 1'b1;
                  end else if (len != 3'd1) begin
                     fend = 1'b1;
                     if (len != '0) next_skip = len_m1[CNT_W-1:0];
                  end else if (is_digit(in_data)) begin
                     result.out_data  = in_data;
                     result.out_valid = 1'b1;
                  end else if (in_data == POINT_CHAR && !cur_state.point_seen) begin
                     nxt_state.point_seen = 1'b1;
                     result.out_data  = in_data;
                     result.out_valid = 1'b1;
                  end else if (in_data == POINT_CHAR) begin
                     fend = 1'b1;
                     result.number_error = 1'b1;
                  end else begin
                     fend = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end

         // field closed: back to field start
         if (fend) begin
            nxt_state.parse_state = ST_START;
            nxt_state.point_seen  = 1'b0;
            nxt_state.copy_count  = '0;
            nxt_state.skip_count  = next_skip;
         end
      end

      // end of line closes any open field and clears everything
      if (line_end) begin
         if (!skipped) fend = 1'b1;
         nxt_state = '0;
      end

      result.field_end = fend;
   end

endmodule

`default_nettype wire

// ===== src/csv_field_tokenizer_core.sv =====
// csv_field_tokenizer_core: byte-serial csv field tokenizer with utf-8 awareness
// depends on csvtok_pkg and csvtok_step
//
//   channel  direction  ports                                  word
//   req      in         req_valid/req_ready                    in_data, line_end
//   rsp      out        rsp_valid/rsp_ready                    out_data ... line_done
//   csr      in/out     psel/penable/pwrite/paddr/pwdata/prdata  delimiter, quote
//
// one byte per cycle unless rsp stalls; the result word follows in the next cycle
// the path is parser state register -> csvtok_step -> result register
// req_ready is high while the result register is empty or being drained
// a stall on rsp holds the result register and the parser state
// synchronous reset clears parser state and result valid, presets the registers
`default_nettype none

module csv_field_tokenizer_core (
   input  logic        clock,
   input  logic        reset,
   // input bytes
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_data,
   input  logic        req_line_end,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_data,
   output logic        rsp_out_valid,
   output logic        rsp_field_end,
   output logic [1:0]  rsp_field_kind,
   output logic        rsp_number_error,
   output logic        rsp_line_done,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import csvtok_pkg::*;

   logic [CHAR_W-1:0] delim_ff;
   logic [CHAR_W-1:0] quote_ff;
   csvtok_state_type  state_ff;
   csvtok_state_type  state_in;
   csvtok_result_type rsp_ff;
   csvtok_result_type rsp_in;
   logic              rsp_valid_ff;
   logic              req_take;
   logic              csr_write;

   // register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_QUOTE) ? {25'd0, quote_ff} : {25'd0, delim_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff <= DELIM_RESET;
         quote_ff <= QUOTE_RESET;
      end else if (csr_write) begin
         if (paddr[2] == REG_DELIM) delim_ff <= pwdata[CHAR_W-1:0];
         else                       quote_ff <= pwdata[CHAR_W-1:0];
      end
   end

   // handshake
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   csvtok_step u_step (
      .cur_state      (state_ff),
      .in_data        (req_in_data),
      .line_end       (req_line_end),
      .delimiter_char (delim_ff),
      .quote_char     (quote_ff),
      .nxt_state      (state_in),
      .result         (rsp_in)
   );

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_data     = rsp_ff.out_data;
   assign rsp_out_valid    = rsp_ff.out_valid;
   assign rsp_field_end    = rsp_ff.field_end;
   assign rsp_field_kind   = rsp_ff.field_kind;
   assign rsp_number_error = rsp_ff.number_error;
   assign rsp_line_done    = rsp_ff.line_done;

`ifndef SYNTHESIS
   // a pending skip only happens between fields
   a_skip_at_start: assert property (@(posedge clock) disable iff (reset)
      state_ff.skip_count != '0 |-> state_ff.parse_state == ST_START)
      else $error("skip count pending inside a field");

   // continuation copies only inside strings and words
   a_copy_in_text: assert property (@(posedge clock) disable iff (reset)
      state_ff.copy_count != '0 |->
         (state_ff.parse_state == ST_QSTR || state_ff.parse_state == ST_WORD))
      else $error("copy count pending outside a string or word");

   // point flag belongs to numbers
   a_point_in_num: assert property (@(posedge clock) disable iff (reset)
      state_ff.point_seen |-> state_ff.parse_state == ST_NUM)
      else $error("point flag set outside a number");

   // end of line returns everything to field start
   a_line_clears: assert property (@(posedge clock) disable iff (reset)
      req_take && req_line_end |=> state_ff == '0)
      else $error("state not cleared after end of line");

   // a line end word always closes its field unless the byte was skipped
   a_line_fend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.line_done && rsp_ff.out_valid |-> rsp_ff.field_end)
      else $error("line end byte left the field open");
`endif

endmodule

`default_nettype wire
